### hdl/box_avg_pkg.sv
// ----------------------------------------------------------------------------
// box_avg_pkg
// Shared types and constants of the box average downsampler.
// ----------------------------------------------------------------------------
package box_avg_pkg;

  localparam int DEF_MAX_COLUMNS = 1024;
  localparam int DEF_MAX_FACTOR  = 16;
  localparam int ROW_LIMIT       = 4096;
  localparam int ROW_POS_W       = $clog2(ROW_LIMIT);

  localparam int PIX_W       = 8;
  localparam int SRC_COLS_W  = 11;
  localparam int SRC_ROWS_W  = 13;
  localparam int FACTOR_W    = 5;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [SRC_COLS_W-1:0] RST_SOURCE_COLUMNS = SRC_COLS_W'(1024);
  localparam logic [SRC_ROWS_W-1:0] RST_SOURCE_ROWS    = SRC_ROWS_W'(1024);
  localparam logic [FACTOR_W-1:0]   RST_BLOCK_FACTOR   = FACTOR_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_COLUMNS = 2'd0,
    CFG_SOURCE_ROWS    = 2'd1,
    CFG_BLOCK_FACTOR   = 2'd2
  } cfg_index_t;

  // per-pixel classification handed from front to back
  typedef struct packed {
    logic first;      // first row of a block row: sum restarts
    logic emit;       // last pixel of a block
    logic row_end;
    logic image_end;
  } flags_t;

endpackage

### hdl/box_average_downsampler.sv
// ----------------------------------------------------------------------------
// box_average_downsampler
// Box filter decimation of a raster grey image by a configurable factor f.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    in_pixel_value
//   out      output     out_valid / out_stall  out_mean_value, out_row_end,
//                                              out_image_end
//   cfg      input      cfg_we                 cfg_index, cfg_wdata
//
// One pixel per cycle while in_stall is low; a result passes the queue and
// the b, c and d registers after its last pixel. After reset and after every
// register write, in_stall is high while the serial divider rebuilds the
// reciprocal of f*f. out_stall freezes the accumulate pipeline; the
// four-entry queue keeps the front accepting until it fills.
// ----------------------------------------------------------------------------
module box_average_downsampler #(
  parameter int MAX_COLUMNS = box_avg_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_FACTOR  = box_avg_pkg::DEF_MAX_FACTOR
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [box_avg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [box_avg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [box_avg_pkg::PIX_W-1:0]       in_pixel_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [box_avg_pkg::PIX_W-1:0]       out_mean_value,
  output logic                                out_row_end,
  output logic                                out_image_end
);

  import box_avg_pkg::*;

  localparam int CLW    = $clog2(MAX_COLUMNS + 1);
  localparam int CW     = $clog2(MAX_COLUMNS);
  localparam int FW     = $clog2(MAX_FACTOR + 1);
  localparam int CXW    = (CLW > SRC_COLS_W) ? CLW : SRC_COLS_W;
  localparam int FXW    = (FW > FACTOR_W) ? FW : FACTOR_W;
  localparam int L      = 2 * $clog2(MAX_FACTOR);
  localparam int AREA_W = L + 1;
  localparam int K      = PIX_W + 2 * L;
  localparam int MW     = K + 1;
  localparam int QW     = PIX_W + CW + $bits(flags_t);

  logic [SRC_COLS_W-1:0] src_cols_r, src_cols_nxt;
  logic [SRC_ROWS_W-1:0] src_rows_r, src_rows_nxt;
  logic [FACTOR_W-1:0]   factor_r, factor_nxt;

  logic [CLW-1:0]        cols;
  logic [SRC_ROWS_W-1:0] rows;
  logic [FW-1:0]         factor;
  logic [AREA_W-1:0]     area;
  logic [MW-1:0]         recip;
  logic                  busy;

  logic                  q_push, q_pop, q_full, q_empty;
  logic [PIX_W-1:0]      f_pix, b_pix;
  logic [CW-1:0]         f_addr, b_addr;
  flags_t                f_flags, b_flags;
  logic [QW-1:0]         q_wdata, q_rdata;

  always_comb begin
    src_cols_nxt = src_cols_r;
    src_rows_nxt = src_rows_r;
    factor_nxt   = factor_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SOURCE_COLUMNS: src_cols_nxt = cfg_wdata[SRC_COLS_W-1:0];
        CFG_SOURCE_ROWS:    src_rows_nxt = cfg_wdata[SRC_ROWS_W-1:0];
        CFG_BLOCK_FACTOR:   factor_nxt   = cfg_wdata[FACTOR_W-1:0];
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_cols_r <= RST_SOURCE_COLUMNS;
      src_rows_r <= RST_SOURCE_ROWS;
      factor_r   <= RST_BLOCK_FACTOR;
    end else begin
      src_cols_r <= src_cols_nxt;
      src_rows_r <= src_rows_nxt;
      factor_r   <= factor_nxt;
    end
  end

  // zero acts as one, oversize as the limit
  always_comb begin
    if (src_cols_r == '0) begin
      cols = CLW'(1);
    end else if (CXW'(src_cols_r) > CXW'(MAX_COLUMNS)) begin
      cols = CLW'(MAX_COLUMNS);
    end else begin
      cols = CLW'(src_cols_r);
    end
    if (src_rows_r == '0) begin
      rows = SRC_ROWS_W'(1);
    end else if (src_rows_r > SRC_ROWS_W'(ROW_LIMIT)) begin
      rows = SRC_ROWS_W'(ROW_LIMIT);
    end else begin
      rows = src_rows_r;
    end
    if (factor_r == '0) begin
      factor = FW'(1);
    end else if (FXW'(factor_r) > FXW'(MAX_FACTOR)) begin
      factor = FW'(MAX_FACTOR);
    end else begin
      factor = FW'(factor_r);
    end
  end

  assign area = AREA_W'(factor) * AREA_W'(factor);

  box_avg_recip #(
    .MAX_FACTOR (MAX_FACTOR)
  ) u_recip (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cfg_we),
    .area  (area),
    .busy  (busy),
    .recip (recip)
  );

  box_avg_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_FACTOR  (MAX_FACTOR)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .restart        (cfg_we),
    .cols           (cols),
    .rows           (rows),
    .factor         (factor),
    .busy           (busy),
    .q_full         (q_full),
    .in_valid       (in_valid),
    .in_pixel_value (in_pixel_value),
    .in_stall       (in_stall),
    .q_push         (q_push),
    .q_pix          (f_pix),
    .q_addr         (f_addr),
    .q_flags        (f_flags)
  );

  assign q_wdata = {f_pix, f_addr, f_flags};

  box_avg_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign {b_pix, b_addr, b_flags} = q_rdata;

  box_avg_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_FACTOR  (MAX_FACTOR)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_pix          (b_pix),
    .q_addr         (b_addr),
    .q_flags        (b_flags),
    .q_pop          (q_pop),
    .area           (area),
    .recip          (recip),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_mean_value (out_mean_value),
    .out_row_end    (out_row_end),
    .out_image_end  (out_image_end)
  );

endmodule

### hdl/box_avg_ram.sv
// ----------------------------------------------------------------------------
// box_avg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module box_avg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/box_avg_fifo.sv
// ----------------------------------------------------------------------------
// box_avg_fifo
// Short queue between the pixel classifier and the accumulate pipeline.
// ----------------------------------------------------------------------------
module box_avg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PW   = $clog2(DEPTH),
  localparam int NW   = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]    count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + NW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata = slot_r[rd_ptr_r];
  assign full  = (count_r == NW'(DEPTH));
  assign empty = (count_r == '0);

endmodule

### hdl/box_avg_recip.sv
// ----------------------------------------------------------------------------
// box_avg_recip
// Bit-serial divider producing m = ceil(2^K / area) for the mean multiply.
// ----------------------------------------------------------------------------
module box_avg_recip #(
  parameter int MAX_FACTOR = box_avg_pkg::DEF_MAX_FACTOR,
  localparam int L    = 2 * $clog2(MAX_FACTOR),
  localparam int AREA_W = L + 1,
  localparam int K    = box_avg_pkg::PIX_W + 2 * L,
  localparam int MW   = K + 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [AREA_W-1:0] area,
  output logic              busy,
  output logic [MW-1:0]     recip
);

  localparam int CNT_W = $clog2(K + 1);

  logic              busy_r, busy_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [AREA_W-1:0] rem_r, rem_nxt;
  logic [MW-1:0]     quo_r, quo_nxt;
  logic [MW-1:0]     recip_r, recip_nxt;
  logic [AREA_W:0]   trial;
  logic              ge;

  assign trial = {rem_r, (cnt_r == CNT_W'(K))};
  assign ge    = (trial >= {1'b0, area});

  always_comb begin
    busy_nxt  = busy_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    recip_nxt = recip_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(K);
      rem_nxt  = '0;
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? AREA_W'(trial - {1'b0, area}) : AREA_W'(trial);
      quo_nxt = {quo_r[MW-2:0], ge};
      if (cnt_r == '0) begin
        busy_nxt  = 1'b0;
        recip_nxt = quo_nxt + MW'(rem_nxt != '0);
      end else begin
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(K);
      rem_r  <= '0;
      quo_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    recip_r <= recip_nxt;
  end

  assign busy  = busy_r;
  assign recip = recip_r;

endmodule

### hdl/box_avg_front.sv
// ----------------------------------------------------------------------------
// box_avg_front
// Raster position tracking; classifies each pixel and queues the kept ones.
// ----------------------------------------------------------------------------
module box_avg_front #(
  parameter int MAX_COLUMNS = box_avg_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_FACTOR  = box_avg_pkg::DEF_MAX_FACTOR,
  localparam int CLW = $clog2(MAX_COLUMNS + 1),
  localparam int CW  = $clog2(MAX_COLUMNS),
  localparam int FW  = $clog2(MAX_FACTOR + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                restart,
  input  logic [CLW-1:0]                      cols,
  input  logic [box_avg_pkg::SRC_ROWS_W-1:0]  rows,
  input  logic [FW-1:0]                       factor,
  input  logic                                busy,
  input  logic                                q_full,
  input  logic                                in_valid,
  input  logic [box_avg_pkg::PIX_W-1:0]       in_pixel_value,
  output logic                                in_stall,
  output logic                                q_push,
  output logic [box_avg_pkg::PIX_W-1:0]       q_pix,
  output logic [CW-1:0]                       q_addr,
  output box_avg_pkg::flags_t                 q_flags
);

  import box_avg_pkg::*;

  localparam int IBW = $clog2(MAX_FACTOR);
  localparam int RPW = ROW_POS_W;
  localparam int CXW = CLW + FW + 1;
  localparam int RXW = SRC_ROWS_W + FW + 1;

  logic [CW-1:0]  col_pos_r, col_pos_nxt;
  logic [CW-1:0]  col_base_r, col_base_nxt;
  logic [CW-1:0]  ocol_r, ocol_nxt;
  logic [IBW-1:0] cib_r, cib_nxt;
  logic [RPW-1:0] row_pos_r, row_pos_nxt;
  logic [RPW-1:0] row_base_r, row_base_nxt;
  logic [IBW-1:0] rib_r, rib_nxt;

  logic           fire;
  logic [CXW-1:0] col_lim;
  logic [RXW-1:0] row_lim;
  logic           col_in, row_in, col_last, row_last;
  logic           col_wrap, row_wrap, cib_wrap, rib_wrap;

  // a block is kept only when it fits entirely inside the image
  assign col_lim  = CXW'(col_base_r) + CXW'(factor);
  assign row_lim  = RXW'(row_base_r) + RXW'(factor);
  assign col_in   = (col_lim <= CXW'(cols));
  assign row_in   = (row_lim <= RXW'(rows));
  assign col_last = ((col_lim + CXW'(factor)) > CXW'(cols));
  assign row_last = ((row_lim + RXW'(factor)) > RXW'(rows));

  assign col_wrap = ((CLW'(col_pos_r) + CLW'(1)) >= cols);
  assign row_wrap = ((SRC_ROWS_W'(row_pos_r) + SRC_ROWS_W'(1)) >= rows);
  assign cib_wrap = ((FW'(cib_r) + FW'(1)) >= factor);
  assign rib_wrap = ((FW'(rib_r) + FW'(1)) >= factor);

  assign in_stall = busy | q_full;
  assign fire     = in_valid & ~in_stall;

  always_comb begin
    col_pos_nxt  = col_pos_r;
    col_base_nxt = col_base_r;
    ocol_nxt     = ocol_r;
    cib_nxt      = cib_r;
    row_pos_nxt  = row_pos_r;
    row_base_nxt = row_base_r;
    rib_nxt      = rib_r;
    priority if (restart) begin
      col_pos_nxt  = '0;
      col_base_nxt = '0;
      ocol_nxt     = '0;
      cib_nxt      = '0;
      row_pos_nxt  = '0;
      row_base_nxt = '0;
      rib_nxt      = '0;
    end else if (fire) begin
      if (col_wrap) begin
        col_pos_nxt  = '0;
        col_base_nxt = '0;
        ocol_nxt     = '0;
        cib_nxt      = '0;
        if (row_wrap) begin
          row_pos_nxt  = '0;
          row_base_nxt = '0;
          rib_nxt      = '0;
        end else begin
          row_pos_nxt = row_pos_r + RPW'(1);
          if (rib_wrap) begin
            rib_nxt      = '0;
            row_base_nxt = row_pos_r + RPW'(1);
          end else begin
            rib_nxt = rib_r + IBW'(1);
          end
        end
      end else begin
        col_pos_nxt = col_pos_r + CW'(1);
        if (cib_wrap) begin
          cib_nxt      = '0;
          ocol_nxt     = ocol_r + CW'(1);
          col_base_nxt = col_pos_r + CW'(1);
        end else begin
          cib_nxt = cib_r + IBW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r  <= '0;
      col_base_r <= '0;
      ocol_r     <= '0;
      cib_r      <= '0;
      row_pos_r  <= '0;
      row_base_r <= '0;
      rib_r      <= '0;
    end else begin
      col_pos_r  <= col_pos_nxt;
      col_base_r <= col_base_nxt;
      ocol_r     <= ocol_nxt;
      cib_r      <= cib_nxt;
      row_pos_r  <= row_pos_nxt;
      row_base_r <= row_base_nxt;
      rib_r      <= rib_nxt;
    end
  end

  assign q_push            = fire & col_in & row_in;
  assign q_pix             = in_pixel_value;
  assign q_addr            = ocol_r;
  assign q_flags.first     = (rib_r == '0);
  assign q_flags.emit      = (FW'(rib_r) == factor - FW'(1)) &&
                             (FW'(cib_r) == factor - FW'(1));
  assign q_flags.row_end   = q_flags.emit & col_last;
  assign q_flags.image_end = q_flags.emit & col_last & row_last;

endmodule

### hdl/box_avg_back.sv
// ----------------------------------------------------------------------------
// box_avg_back
// Accumulate pipeline: sum store read/modify/write, rounding bias, reciprocal
// multiply, output register.
// ----------------------------------------------------------------------------
module box_avg_back #(
  parameter int MAX_COLUMNS = box_avg_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_FACTOR  = box_avg_pkg::DEF_MAX_FACTOR,
  localparam int CW     = $clog2(MAX_COLUMNS),
  localparam int L      = 2 * $clog2(MAX_FACTOR),
  localparam int AREA_W = L + 1,
  localparam int K      = box_avg_pkg::PIX_W + 2 * L,
  localparam int MW     = K + 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  logic [box_avg_pkg::PIX_W-1:0] q_pix,
  input  logic [CW-1:0]                 q_addr,
  input  box_avg_pkg::flags_t           q_flags,
  output logic                          q_pop,
  input  logic [AREA_W-1:0]             area,
  input  logic [MW-1:0]                 recip,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [box_avg_pkg::PIX_W-1:0] out_mean_value,
  output logic                          out_row_end,
  output logic                          out_image_end
);

  import box_avg_pkg::*;

  localparam int SW = $clog2(((1 << PIX_W) - 1) * MAX_FACTOR * MAX_FACTOR + 1);
  localparam int NW = PIX_W + L;
  localparam int PRW = NW + MW;

  logic           advance;

  logic           b_vld_r;
  logic [PIX_W-1:0] b_pix_r;
  logic [CW-1:0]  b_addr_r;
  flags_t         b_flags_r;
  logic [SW-1:0]  rdata;
  logic [SW-1:0]  prev_sum;
  logic [SW-1:0]  sum;

  logic           fwd_vld_r;
  logic [CW-1:0]  fwd_addr_r;
  logic [SW-1:0]  fwd_sum_r;

  logic           c_vld_r;
  logic [NW-1:0]  c_n_r;
  logic           c_row_end_r, c_image_end_r;

  logic           d_vld_r;
  logic [PRW-1:0] d_p_r;
  logic           d_row_end_r, d_image_end_r;

  assign advance = ~d_vld_r | ~out_stall;
  assign q_pop   = advance & ~q_empty;

  box_avg_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_COLUMNS)
  ) u_sums (
    .clk   (clk),
    .we    (advance & b_vld_r),
    .waddr (b_addr_r),
    .wdata (sum),
    .re    (q_pop),
    .raddr (q_addr),
    .rdata (rdata)
  );

  // the write issued alongside this entry's read is not yet in rdata
  always_comb begin
    if (b_flags_r.first) begin
      prev_sum = '0;
    end else if (fwd_vld_r && (fwd_addr_r == b_addr_r)) begin
      prev_sum = fwd_sum_r;
    end else begin
      prev_sum = rdata;
    end
  end

  assign sum = prev_sum + SW'(b_pix_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r   <= 1'b0;
      fwd_vld_r <= 1'b0;
      c_vld_r   <= 1'b0;
      d_vld_r   <= 1'b0;
    end else if (advance) begin
      b_vld_r   <= ~q_empty;
      fwd_vld_r <= b_vld_r;
      c_vld_r   <= b_vld_r & b_flags_r.emit;
      d_vld_r   <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b_pix_r       <= q_pix;
      b_addr_r      <= q_addr;
      b_flags_r     <= q_flags;
      fwd_addr_r    <= b_addr_r;
      fwd_sum_r     <= sum;
      c_n_r         <= NW'(sum) + NW'(area >> 1);
      c_row_end_r   <= b_flags_r.row_end;
      c_image_end_r <= b_flags_r.image_end;
      d_p_r         <= PRW'(c_n_r) * PRW'(recip);
      d_row_end_r   <= c_row_end_r;
      d_image_end_r <= c_image_end_r;
    end
  end

  assign out_valid      = d_vld_r;
  assign out_mean_value = d_p_r[K +: PIX_W];
  assign out_row_end    = d_row_end_r;
  assign out_image_end  = d_image_end_r;

endmodule

### hdl/box_avg_checker.sv
// ----------------------------------------------------------------------------
// box_avg_checker
// Port-level checks on the box average downsampler, bound to the top level.
// ----------------------------------------------------------------------------
module box_avg_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          cfg_we,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [box_avg_pkg::PIX_W-1:0] out_mean_value,
  input logic                          out_row_end,
  input logic                          out_image_end
);

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_mean_value) &&
      $stable(out_row_end) && $stable(out_image_end))
    else $error("stalled output word changed");

  a_image_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_row_end || !out_image_end))
    else $error("image_end without row_end");

  a_cfg_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> in_stall)
    else $error("input open while reciprocal is rebuilt");

  a_reset_stalls_input: assert property (@(posedge clk)
    $rose(rst_n) |-> in_stall)
    else $error("input open right after reset");

endmodule

bind box_average_downsampler box_avg_checker u_box_avg_checker (.*);
